// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// unconditional check that also holds during reset
`define ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ===== hdl/d2i_pkg.sv =====
// package for the double to integer converter
// types and constants shared by the converter modules
`default_nettype none
package d2i_pkg;
    localparam int unsigned ExpW  = 11;
    localparam int unsigned MantW = 52;
    localparam logic [ExpW-1:0] ExpMax = 11'h7FF;
    localparam logic [1:0] W8 = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;
    localparam logic [1:0] W64 = 2'd3;

    typedef struct packed {
        logic [63:0] float_bits;
        logic        is_signed;
        logic [1:0]  width_code;
    } d2i_in_t;

    typedef struct packed {
        logic [63:0] int_bits;
        logic        in_range;
    } d2i_out_t;
endpackage
`default_nettype wire

// ===== hdl/d2i_convert.sv =====
// combinational conversion of one double to a saturated integer
// depends on d2i_pkg
`default_nettype none
module d2i_convert
    import d2i_pkg::*;
(
    input  wire d2i_in_t req,
    output d2i_out_t     res
);
    logic            neg;
    logic [ExpW-1:0] expo;
    logic [MantW-1:0] mant;
    logic [52:0]     sig;
    logic [64:0]     shl;
    logic [53:0]     shr;
    logic [64:0]     mag;
    logic            huge;
    logic            is_nan;
    logic [63:0]     half;
    logic [63:0]     umax;
    logic [5:0]      rs;

    always_comb
    begin
        neg    = req.float_bits[63];
        expo   = req.float_bits[62:52];
        mant   = req.float_bits[51:0];
        sig    = {1'b1, mant};
        is_nan = (expo == ExpMax) && (mant != '0);
        huge   = (expo == ExpMax) || (expo >= 11'd1087);
        rs     = 6'd0;
        shl    = '0;
        shr    = '0;
        mag    = '0;
        if (expo == '0 || huge)
        begin
            mag = '0;
        end
        else if (expo >= 11'd1075)
        begin
            shl = {12'd0, sig} << (expo - 11'd1075);
            mag = shl;
        end
        else if (expo >= 11'd1021)
        begin
            // bit 1 is the guard bit, round half away from zero
            rs  = 6'(11'd1075 - expo - 11'd1);
            shr = {sig, 1'b0} >> rs;
            mag = {13'd0, shr[53:2]} + {64'd0, shr[1]};
        end
        else
        begin
            mag = '0;
        end

        case (req.width_code)
            W8:      half = 64'h80;
            W16:     half = 64'h8000;
            W32:     half = 64'h8000_0000;
            default: half = 64'h8000_0000_0000_0000;
        endcase
        umax = {half[62:0], 1'b0} - 64'd1;

        if (is_nan)
        begin
            res.int_bits = '0;
            res.in_range = 1'b0;
        end
        else if (req.is_signed)
        begin
            if (!neg)
            begin
                if (huge || mag > {1'b0, half - 64'd1})
                begin
                    res.int_bits = half - 64'd1;
                    res.in_range = 1'b0;
                end
                else
                begin
                    res.int_bits = mag[63:0];
                    res.in_range = 1'b1;
                end
            end
            else if (huge || mag > {1'b0, half})
            begin
                res.int_bits = 64'd0 - half;
                res.in_range = 1'b0;
            end
            else
            begin
                res.int_bits = 64'd0 - mag[63:0];
                res.in_range = 1'b1;
            end
        end
        else if (neg)
        begin
            res.int_bits = '0;
            res.in_range = !huge && (mag == '0);
        end
        else if (huge || mag > {1'b0, umax})
        begin
            res.int_bits = umax;
            res.in_range = 1'b0;
        end
        else
        begin
            res.int_bits = mag[63:0];
            res.in_range = 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/double_to_int_round_saturate.sv =====
// channel  | dir | payload   | handshake
// in       | in  | d2i_in_t  | in_valid / in_stall
// out      | out | d2i_out_t | out_valid / out_stall
// one request per cycle while out_stall is low; input register, then result register
// the conversion is one pass of logic between the two registers
// reset clears both valid bits; payload registers are not reset
// a stalled result holds; the input stage keeps moving while the result slot frees
// top level of the double to integer converter, depends on d2i_pkg and d2i_convert
`default_nettype none
`include "assert_macros.svh"
module double_to_int_round_saturate
    import d2i_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire d2i_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output d2i_out_t      out_data
);
    logic     in_vld_reg, out_vld_reg;
    d2i_in_t  in_reg;
    d2i_out_t out_reg, conv_res;
    logic     adv_out, adv_in;

    d2i_convert u_conv (.req(in_reg), .res(conv_res));

    assign adv_out  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !adv_out;
    assign adv_in   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv_in || adv_out)
                in_vld_reg <= adv_in;
            if (adv_out)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in)
            in_reg <= in_data;
        if (adv_out)
            out_reg <= conv_res;
    end

    `ASSERT_IMPL(a_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid && $stable(out_data), "stalled result changed")
    `ASSERT_IMPL(a_nan, clk, rst_n, (adv_out && in_reg.float_bits[62:52] == ExpMax && in_reg.float_bits[51:0] != '0) |=> (out_data.int_bits == '0 && !out_data.in_range), "nan not flagged")
    `ASSERT_ALWAYS(a_stall, clk, (!in_vld_reg) |-> !in_stall, "stall with empty input stage")
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for double_to_int_round_saturate: directed and random conversion requests
// checked against an in-bench rounding/saturation predictor; depends on d2i_pkg
`timescale 1ns / 1ps
module tb_top;
    import d2i_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    d2i_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    d2i_out_t out_data;

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    bit          hold_off = 1'b0;

    localparam int unsigned CycleLimit = 200000;

    double_to_int_round_saturate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic d2i_out_t convert_double(input d2i_in_t req);
        d2i_out_t    res;
        logic        neg;
        logic [10:0] expo;
        logic [51:0] mant;
        logic [52:0] sig;
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] umax;
        logic        huge;
        int          shift;
        int          rs;
        int          w;
        neg  = req.float_bits[63];
        expo = req.float_bits[62:52];
        mant = req.float_bits[51:0];
        w    = 8 << req.width_code;
        huge = 1'b0;
        mag  = '0;
        res  = '0;
        if (expo == ExpMax && mant != '0)
            return res;
        if (expo == ExpMax)
            huge = 1'b1;
        else if (expo != '0)
        begin
            sig = {1'b1, mant};
            shift = int'(expo) - 1075;
            if (shift >= 12)
                huge = 1'b1;
            else if (shift >= 0)
                mag = 64'(sig) << shift;
            else
            begin
                rs = -shift;
                if (rs <= 53)
                    mag = (64'(sig) >> rs) + ((64'(sig) >> (rs - 1)) & 64'd1);
            end
        end
        half = 64'd1 << (w - 1);
        umax = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        if (req.is_signed)
        begin
            if (!neg)
            begin
                if (huge || mag > half - 64'd1) res = '{half - 64'd1, 1'b0};
                else res = '{mag, 1'b1};
            end
            else
            begin
                if (huge || mag > half) res = '{64'd0 - half, 1'b0};
                else res = '{64'd0 - mag, 1'b1};
            end
        end
        else if (neg)
            res = '{64'd0, !huge && mag == '0};
        else if (huge || mag > umax)
            res = '{umax, 1'b0};
        else
            res = '{mag, 1'b1};
        return res;
    endfunction

    class conversion_scoreboard;
        d2i_out_t pending[$];

        function void note_request(d2i_in_t req);
            pending.push_back(convert_double(req));
        endfunction

        task check_result(d2i_out_t got);
            d2i_out_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", got.int_bits, '0);
                return;
            end
            want = pending.pop_front();
            if (got.int_bits !== want.int_bits)
                report_mismatch("int_bits", got.int_bits, want.int_bits);
            if (got.in_range !== want.in_range)
                report_mismatch("in_range", 64'(got.in_range), 64'(want.in_range));
        endtask
    endclass

    conversion_scoreboard sb = new();

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
        if (cycles > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall, changes at falling edge
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // valid stays high after acceptance so back to back requests need one assignment
    task automatic send_request(input d2i_in_t req);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3: b[62:52] = 11'(1023 + $urandom_range(0, 66)) - 11'd4;
            4: b[62:52] = 11'(1075 - $urandom_range(0, 55));
            5: b[51:0] = {3'($urandom_range(7)), 49'd0};
            6: b[62:52] = ExpMax;
            7: b[62:52] = '0;
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [63:0] exp_val(input logic s, input int e, input logic [51:0] m);
        return {s, 11'(e), m};
    endfunction

    initial
    begin
        logic [63:0] dir[$];
        d2i_in_t     req;
        int          ph;
        dir = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                64'h3FD3_3333_3333_3333, 64'hBFD3_3333_3333_3333, 64'h4004_0000_0000_0000,
                64'h405F_E000_0000_0000, 64'h4060_0000_0000_0000, 64'hC060_0000_0000_0000,
                64'hC060_1000_0000_0000, 64'h43F0_0000_0000_0000, 64'h43EF_FFFF_FFFF_FFFF,
                64'hC3E0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir[i])
        begin
            req.float_bits = dir[i];
            req.is_signed  = i[0];
            req.width_code = 2'(i >> 1);
            send_request(req);
        end
        for (int k = 0; k < 8; k++)
        begin
            req = '{exp_val(k[0], 1086 - k, 52'hF_FFFF_FFFF_FFFF), k[1], W64};
            send_request(req);
        end
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
                3: begin snd_idle_pct = 8;  rcv_stall_pct = 8;  end
                default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
            endcase
            if (ph == 4)
            begin
                // long hold-off so the pipeline fills and stalls the input
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (40) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (100)
            begin
                req.float_bits = random_double();
                req.is_signed  = 1'($urandom);
                req.width_code = 2'($urandom_range(3));
                send_request(req);
            end
        end
        in_valid <= 1'b0;
        rcv_stall_pct = 0;
        hold_off = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
